FILE: rtl/opa_pkg.sv
// Shared constants, codes and types of the obstacle penalty accumulator.
package opa_pkg;

  localparam int MaxObstacles = 16;
  localparam int MaxVertices  = 64;
  localparam int FracBits     = 16;
  localparam int ObsAw        = $clog2(MaxObstacles);
  localparam int VtxAw        = $clog2(MaxVertices);
  localparam int SumW         = 56;
  localparam int OutW         = 48;

  localparam logic [1:0] OpLoadObs = 2'd0;
  localparam logic [1:0] OpLoadVtx = 2'd1;
  localparam logic [1:0] OpPoint   = 2'd2;

  localparam logic [1:0] KindCircle = 2'd0;
  localparam logic [1:0] KindConvex = 2'd1;

  localparam logic CfgObstacleCount = 1'b0;
  localparam logic CfgPointsPerPath = 1'b1;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        radius;
    logic [30:0]        weight;
    logic [5:0]         vfirst;
    logic [6:0]         vcount;
  } obstacle_t;

  // Request to the shared divide / square root unit.
  typedef struct packed {
    logic        start;
    logic        is_sqrt;
    logic [65:0] num;
    logic [32:0] den;
    logic [6:0]  steps;
  } unit_req_t;

  typedef struct packed {
    logic        busy;
    logic [55:0] result;
  } unit_rsp_t;

endpackage

FILE: rtl/opa_if.sv
// Valid/ready channel interfaces for path items and penalty results.
interface opa_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [5:0]         slot;
  logic [1:0]         kind;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic [30:0]        radius;
  logic [30:0]        weight;
  logic [5:0]         vertex_first;
  logic [6:0]         vertex_count;
  logic               last_in_path;
  logic               last_in_batch;

  modport source (output valid, op, slot, kind, coord_x, coord_y, radius, weight,
                  vertex_first, vertex_count, last_in_path, last_in_batch,
                  input ready);
  modport sink (input valid, op, slot, kind, coord_x, coord_y, radius, weight,
                vertex_first, vertex_count, last_in_path, last_in_batch,
                output ready);
endinterface

interface opa_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] path_penalty_value;
  logic [4:0]  obstacles_hit;
  logic        batch_done;

  modport source (output valid, path_penalty_value, obstacles_hit, batch_done,
                  input ready);
  modport sink (input valid, path_penalty_value, obstacles_hit, batch_done,
                output ready);
endinterface

FILE: rtl/obstacle_penalty_accumulator_top.sv
// Top level of the obstacle penalty accumulator: sequencer, tables and multiplier.
//
// Load words (op 0 obstacle, op 1 polygon vertex) and path point words enter on
// in_i; results leave on out_o. Configuration is written on cfg_we_i with
// cfg_idx_i selecting obstacle_count (0) or points_per_path (1).
// A load word is taken while idle and the block stays ready for the next word.
// A path point is walked over the obstacles in use one after another; per
// obstacle it does setup and multiplies, a square root in the shared divide/root
// unit, for a polygon a fetch of the closing vertex and then one pass per edge,
// and a division when the point is inside. A point that closes a path adds a
// division for the mean. The block is not ready while a point is being worked
// on; the shared unit and the single read port of each table serialise this
// work.
// A result is held in an output register until taken, and the next word is
// accepted meanwhile; a later result waits in the divider until the register
// frees, and only then does the block take new words.
// Reset clears the penalty sum, the hit flags and the control state and sets
// obstacle_count to 0, points_per_path to 1. Table contents are undefined until
// loaded.
module obstacle_penalty_accumulator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  opa_in_if.sink      in_i,
  opa_out_if.source   out_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_OB_RD  = 5'd1;
  localparam logic [4:0] S_OB_LAT = 5'd2;
  localparam logic [4:0] S_DX     = 5'd3;
  localparam logic [4:0] S_SQX    = 5'd4;
  localparam logic [4:0] S_SQY    = 5'd5;
  localparam logic [4:0] S_SQS    = 5'd6;
  localparam logic [4:0] S_SQRT   = 5'd7;
  localparam logic [4:0] S_KIND   = 5'd8;
  localparam logic [4:0] S_PV_RD  = 5'd9;
  localparam logic [4:0] S_PV_LAT = 5'd10;
  localparam logic [4:0] S_CV_RD  = 5'd11;
  localparam logic [4:0] S_CV_LAT = 5'd12;
  localparam logic [4:0] S_E1     = 5'd13;
  localparam logic [4:0] S_E2     = 5'd14;
  localparam logic [4:0] S_E3     = 5'd15;
  localparam logic [4:0] S_HIT    = 5'd16;
  localparam logic [4:0] S_DIV    = 5'd17;
  localparam logic [4:0] S_NEXT   = 5'd18;
  localparam logic [4:0] S_FINISH = 5'd19;
  localparam logic [4:0] S_MEAN   = 5'd20;

  localparam logic [55:0] SumMax = {opa_pkg::SumW{1'b1}};

  logic [4:0]  state_q, state_d;
  logic [4:0]  obs_cnt_q;
  logic [10:0] ppp_q;

  logic signed [31:0] px_q, py_q;
  logic               lpath_q, lbatch_q;
  logic [4:0]         n_q;
  logic [opa_pkg::ObsAw-1:0] ob_q;
  opa_pkg::obstacle_t ent_q;
  logic [31:0] mx_q, my_q;
  logic [63:0] prod_q, acc_q;
  logic [32:0] dist_q;
  logic [6:0]  vcnt_q, vi_q;
  logic [opa_pkg::VtxAw-1:0] vaddr_q;
  logic [63:0] prev_q, cur_q;
  logic        s1_q, s2_q, n1_q;
  logic [63:0] m1_q;
  logic [55:0] sum_q;
  logic [opa_pkg::MaxObstacles-1:0] hit_q;
  logic [4:0]  hit_cnt_q;

  logic        out_valid_q;
  logic [47:0] out_pen_q;
  logic [4:0]  out_hits_q;
  logic        out_batch_q;

  logic        accept;
  logic        out_load;
  logic        obs_we, vtx_we;
  opa_pkg::obstacle_t obs_wdata, obs_rdata;
  logic [63:0] vtx_rdata;

  opa_pkg::unit_req_t req;
  opa_pkg::unit_rsp_t rsp;

  logic [31:0] mul_a, mul_b;
  logic signed [32:0] ea, eb;
  logic [32:0] dcx, dcy;
  logic        n2, edge_in;
  logic [64:0] sq_sum;
  logic [56:0] sum_add;
  logic [55:0] term;

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic signed [32:0] a;
    a = v[32] ? -v : v;
    return a[31:0];
  endfunction

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_load = (state_q == S_MEAN) && !rsp.busy && (!out_valid_q || out_o.ready);

  assign obs_we = accept && (in_i.op == opa_pkg::OpLoadObs) &&
                  ({1'b0, in_i.slot} < 7'(opa_pkg::MaxObstacles));
  assign vtx_we = accept && (in_i.op == opa_pkg::OpLoadVtx) &&
                  ({1'b0, in_i.slot} < 7'(opa_pkg::MaxVertices));

  always_comb begin
    obs_wdata.kind   = in_i.kind;
    obs_wdata.cx     = in_i.coord_x;
    obs_wdata.cy     = in_i.coord_y;
    obs_wdata.radius = in_i.radius;
    obs_wdata.weight = in_i.weight;
    obs_wdata.vfirst = in_i.vertex_first;
    obs_wdata.vcount = in_i.vertex_count;
  end

  opa_ram #(
    .Width($bits(opa_pkg::obstacle_t)),
    .Depth(opa_pkg::MaxObstacles)
  ) u_obs_ram (
    .clk_i  (clk_i),
    .we_i   (obs_we),
    .waddr_i(in_i.slot[opa_pkg::ObsAw-1:0]),
    .wdata_i(obs_wdata),
    .raddr_i(ob_q),
    .rdata_o(obs_rdata)
  );

  opa_ram #(
    .Width(64),
    .Depth(opa_pkg::MaxVertices)
  ) u_vtx_ram (
    .clk_i  (clk_i),
    .we_i   (vtx_we),
    .waddr_i(in_i.slot[opa_pkg::VtxAw-1:0]),
    .wdata_i({in_i.coord_y, in_i.coord_x}),
    .raddr_i(vaddr_q),
    .rdata_o(vtx_rdata)
  );

  opa_divsqrt u_unit (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  // Edge operands: the first product uses (py - vy, cx - vx), the second
  // (px - vx, cy - vy), where v is the previous and c the current vertex.
  always_comb begin
    if (state_q == S_E1) begin
      ea = 33'(py_q) - 33'($signed(prev_q[63:32]));
      eb = 33'($signed(cur_q[31:0])) - 33'($signed(prev_q[31:0]));
    end else begin
      ea = 33'(px_q) - 33'($signed(prev_q[31:0]));
      eb = 33'($signed(cur_q[63:32])) - 33'($signed(prev_q[63:32]));
    end
    dcx = 33'(px_q) - 33'(ent_q.cx);
    dcy = 33'(py_q) - 33'(ent_q.cy);
    case (state_q)
      S_SQX: begin
        mul_a = mx_q;
        mul_b = mx_q;
      end
      S_SQY: begin
        mul_a = my_q;
        mul_b = my_q;
      end
      default: begin
        mul_a = mag33(ea);
        mul_b = mag33(eb);
      end
    endcase
    n2      = s2_q && (prod_q != 64'd0);
    edge_in = (n1_q != n2) ? n2 : (n1_q ? (m1_q < prod_q) : (m1_q > prod_q));
    sq_sum  = {1'b0, acc_q} + {1'b0, prod_q};
    term    = (state_q == S_HIT) ? SumMax : rsp.result;
    sum_add = {1'b0, sum_q} + {1'b0, term};
  end

  always_comb begin
    req.start   = 1'b0;
    req.is_sqrt = 1'b0;
    req.num     = '0;
    req.den     = 33'd1;
    req.steps   = 7'd56;
    case (state_q)
      S_SQS: begin
        req.start   = 1'b1;
        req.is_sqrt = 1'b1;
        req.num     = {1'b0, sq_sum};
        req.steps   = 7'd33;
      end
      S_HIT: begin
        req.start = (dist_q != 33'd0);
        req.num   = {{(66 - 31 - opa_pkg::FracBits - 10){1'b0}}, ent_q.weight,
                     {opa_pkg::FracBits{1'b0}}, 10'd0};
        req.den   = dist_q;
      end
      S_FINISH: begin
        req.start = lpath_q || lbatch_q;
        req.num   = {sum_q, 10'd0};
        req.den   = (ppp_q == 11'd0) ? 33'd1 : {22'd0, ppp_q};
      end
      default: begin
        req.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (in_i.op == opa_pkg::OpPoint)) begin
          state_d = S_FINISH;
          if (obs_cnt_q != 5'd0) begin
            state_d = S_OB_RD;
          end
        end
      end
      S_OB_RD:  state_d = S_OB_LAT;
      S_OB_LAT: state_d = S_DX;
      S_DX:     state_d = S_SQX;
      S_SQX:    state_d = S_SQY;
      S_SQY:    state_d = S_SQS;
      S_SQS:    state_d = S_SQRT;
      S_SQRT: begin
        if (!rsp.busy) begin
          state_d = S_KIND;
        end
      end
      S_KIND: begin
        state_d = S_NEXT;
        if (ent_q.kind == opa_pkg::KindCircle) begin
          if ({2'b00, ent_q.radius} > dist_q) begin
            state_d = S_HIT;
          end
        end else if (ent_q.kind == opa_pkg::KindConvex) begin
          if (ent_q.vcount != 7'd0) begin
            state_d = S_PV_RD;
          end
        end
      end
      S_PV_RD:  state_d = S_PV_LAT;
      S_PV_LAT: state_d = S_CV_RD;
      S_CV_RD:  state_d = S_CV_LAT;
      S_CV_LAT: state_d = S_E1;
      S_E1:     state_d = S_E2;
      S_E2:     state_d = S_E3;
      S_E3: begin
        if (!edge_in) begin
          state_d = S_NEXT;
        end else if (vi_q + 7'd1 == vcnt_q) begin
          state_d = S_HIT;
        end else begin
          state_d = S_CV_RD;
        end
      end
      S_HIT: state_d = (dist_q == 33'd0) ? S_NEXT : S_DIV;
      S_DIV: begin
        if (!rsp.busy) begin
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        state_d = ({1'b0, ob_q} + 5'd1 == n_q) ? S_FINISH : S_OB_RD;
      end
      S_FINISH: state_d = (lpath_q || lbatch_q) ? S_MEAN : S_IDLE;
      S_MEAN: begin
        if (!rsp.busy && (!out_valid_q || out_o.ready)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      obs_cnt_q   <= 5'd0;
      ppp_q       <= 11'd1;
      sum_q       <= '0;
      hit_q       <= '0;
      hit_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      ob_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == opa_pkg::CfgObstacleCount) begin
          obs_cnt_q <= cfg_data_i[4:0];
        end else begin
          ppp_q <= cfg_data_i;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: ob_q <= '0;
        S_NEXT: ob_q <= ob_q + 1'b1;
        S_HIT: begin
          if (!hit_q[ob_q]) begin
            hit_cnt_q <= hit_cnt_q + 5'd1;
          end
          hit_q[ob_q] <= 1'b1;
          if (dist_q == 33'd0) begin
            sum_q <= sum_add[56] ? SumMax : sum_add[55:0];
          end
        end
        S_DIV: begin
          if (!rsp.busy) begin
            sum_q <= sum_add[56] ? SumMax : sum_add[55:0];
          end
        end
        S_MEAN: begin
          if (out_load) begin
            sum_q <= '0;
            if (lbatch_q) begin
              hit_q     <= '0;
              hit_cnt_q <= '0;
            end
          end
        end
        default: begin
          ob_q <= ob_q;
        end
      endcase
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        px_q     <= in_i.coord_x;
        py_q     <= in_i.coord_y;
        lpath_q  <= in_i.last_in_path;
        lbatch_q <= in_i.last_in_batch;
        n_q      <= (obs_cnt_q > 5'(opa_pkg::MaxObstacles)) ?
                    5'(opa_pkg::MaxObstacles) : obs_cnt_q;
      end
      S_OB_LAT: ent_q <= obs_rdata;
      S_DX: begin
        mx_q <= mag33(dcx);
        my_q <= mag33(dcy);
      end
      S_SQX: prod_q <= mul_a * mul_b;
      S_SQY: begin
        prod_q <= mul_a * mul_b;
        acc_q  <= prod_q;
      end
      S_SQRT: dist_q <= rsp.result[32:0];
      S_KIND: begin
        vcnt_q  <= (ent_q.vcount > 7'(opa_pkg::MaxVertices)) ?
                   7'(opa_pkg::MaxVertices) : ent_q.vcount;
        vaddr_q <= ent_q.vfirst + 6'(((ent_q.vcount > 7'(opa_pkg::MaxVertices)) ?
                   7'(opa_pkg::MaxVertices) : ent_q.vcount) - 7'd1);
        vi_q    <= 7'd0;
      end
      S_PV_LAT: begin
        prev_q  <= vtx_rdata;
        vaddr_q <= ent_q.vfirst;
      end
      S_CV_LAT: cur_q <= vtx_rdata;
      S_E1: begin
        prod_q <= mul_a * mul_b;
        s1_q   <= ea[32] ^ eb[32];
      end
      S_E2: begin
        prod_q <= mul_a * mul_b;
        m1_q   <= prod_q;
        n1_q   <= s1_q && (prod_q != 64'd0);
        s2_q   <= ea[32] ^ eb[32];
      end
      S_E3: begin
        prev_q  <= cur_q;
        vi_q    <= vi_q + 7'd1;
        vaddr_q <= ent_q.vfirst + vi_q[5:0] + 6'd1;
      end
      S_MEAN: begin
        if (out_load) begin
          out_pen_q   <= (rsp.result[55:48] != 8'd0) ? {opa_pkg::OutW{1'b1}} :
                         rsp.result[47:0];
          out_hits_q  <= lbatch_q ? hit_cnt_q : 5'd0;
          out_batch_q <= lbatch_q;
        end
      end
      default: begin
        px_q <= px_q;
      end
    endcase
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.path_penalty_value = out_pen_q;
  assign out_o.obstacles_hit      = out_hits_q;
  assign out_o.batch_done         = out_batch_q;

endmodule

FILE: rtl/opa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module opa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/opa_divsqrt.sv
// Shared restoring unit: one quotient or root bit per cycle.
module opa_divsqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  opa_pkg::unit_req_t req_i,
  output opa_pkg::unit_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic        sqrt_q, sqrt_d;
  logic [65:0] num_q, num_d;
  logic [32:0] den_q, den_d;
  logic [35:0] rem_q, rem_d;
  logic [55:0] res_q, res_d;
  logic [6:0]  cnt_q, cnt_d;

  logic [35:0] rem_sh;
  logic [35:0] operand;
  logic [36:0] diff;

  always_comb begin
    if (sqrt_q) begin
      rem_sh  = {rem_q[33:0], num_q[65:64]};
      operand = {res_q[33:0], 2'b01};
    end else begin
      rem_sh  = {rem_q[34:0], num_q[65]};
      operand = {3'b000, den_q};
    end
    diff = {1'b0, rem_sh} - {1'b0, operand};
  end

  always_comb begin
    busy_d = busy_q;
    sqrt_d = sqrt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    res_d  = res_q;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      sqrt_d = req_i.is_sqrt;
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      res_d  = '0;
      cnt_d  = req_i.steps;
    end else if (busy_q) begin
      num_d = sqrt_q ? {num_q[63:0], 2'b00} : {num_q[64:0], 1'b0};
      if (!diff[36]) begin
        rem_d = diff[35:0];
        res_d = {res_q[54:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        res_d = {res_q[54:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sqrt_q <= sqrt_d;
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.result = res_q;

endmodule

FILE: bench/opa_checker.sv
// Checker that predicts and compares the penalty results of the obstacle accumulator.
module opa_checker
  import opa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  opa_in_if           in_w,
  opa_out_if          out_w,
  output int          fail_o,
  output int          pending_o
);

  localparam logic [55:0] SumSat = {SumW{1'b1}};
  localparam logic [55:0] OutSat = {8'd0, {OutW{1'b1}}};

  typedef struct {
    logic [47:0] penalty;
    logic [4:0]  hits;
    logic        done;
  } penalty_res_t;

  penalty_res_t penalty_q[$];

  logic [1:0]         obs_kind   [MaxObstacles];
  logic signed [31:0] obs_cx     [MaxObstacles];
  logic signed [31:0] obs_cy     [MaxObstacles];
  logic [30:0]        obs_radius [MaxObstacles];
  logic [30:0]        obs_weight [MaxObstacles];
  logic [5:0]         obs_vfirst [MaxObstacles];
  logic [6:0]         obs_vcount [MaxObstacles];
  logic signed [31:0] vtx_x      [MaxVertices];
  logic signed [31:0] vtx_y      [MaxVertices];
  logic [55:0]        penalty_sum;
  logic [MaxObstacles-1:0] hit_flags;
  logic [4:0]         obstacle_count;
  logic [10:0]        points_per_path;

  function automatic logic [32:0] floor_sqrt(input logic [65:0] v);
    logic [67:0] rem;
    logic [67:0] trial;
    logic [33:0] root;
    rem  = '0;
    root = '0;
    for (int k = 32; k >= 0; k--) begin
      rem   = (rem << 2) | 68'(v[2*k +: 2]);
      root  = root << 1;
      trial = 68'({root, 1'b1});
      if (rem >= trial) begin
        rem  = rem - trial;
        root = root | 34'd1;
      end
    end
    return root[32:0];
  endfunction

  // The point is inside when it lies strictly left of every edge.
  function automatic bit in_convex(input int ob, input logic signed [31:0] px,
                                   input logic signed [31:0] py);
    int cnt;
    int ci;
    int pi;
    logic signed [33:0] a1, b1, a2, b2;
    logic signed [67:0] p1, p2;
    cnt = obs_vcount[ob];
    if (cnt > MaxVertices) cnt = MaxVertices;
    if (cnt == 0) return 1'b0;
    for (int i = 0; i < cnt; i++) begin
      ci = (obs_vfirst[ob] + i) % MaxVertices;
      pi = (obs_vfirst[ob] + (i + cnt - 1) % cnt) % MaxVertices;
      a1 = py - vtx_y[pi];
      b1 = vtx_x[ci] - vtx_x[pi];
      a2 = px - vtx_x[pi];
      b2 = vtx_y[ci] - vtx_y[pi];
      p1 = a1 * b1;
      p2 = a2 * b2;
      if (!(p1 > p2)) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic accumulate_point(input logic signed [31:0] px,
                                  input logic signed [31:0] py,
                                  input logic lp, input logic lb);
    int n;
    logic signed [32:0] dx, dy;
    logic [32:0] mx, my, span;
    logic [65:0] sq;
    logic [63:0] term;
    logic [56:0] s;
    logic [55:0] mean;
    logic [10:0] div;
    bit hit;
    penalty_res_t r;
    n = (obstacle_count > MaxObstacles) ? MaxObstacles : obstacle_count;
    for (int ob = 0; ob < n; ob++) begin
      dx   = px - obs_cx[ob];
      dy   = py - obs_cy[ob];
      mx   = dx[32] ? 33'(-dx) : 33'(dx);
      my   = dy[32] ? 33'(-dy) : 33'(dy);
      sq   = ({33'd0, mx} * {33'd0, mx}) + ({33'd0, my} * {33'd0, my});
      span = floor_sqrt(sq);
      hit  = 1'b0;
      if (obs_kind[ob] == KindCircle) hit = {2'b0, obs_radius[ob]} > span;
      else if (obs_kind[ob] == KindConvex) hit = in_convex(ob, px, py);
      if (hit) begin
        hit_flags[ob] = 1'b1;
        if (span == 0) term = 64'(SumSat);
        else term = {17'd0, obs_weight[ob], 16'd0} / {31'd0, span};
        if (term > 64'(SumSat)) term = 64'(SumSat);
        s = {1'b0, penalty_sum} + term[56:0];
        penalty_sum = (s > {1'b0, SumSat}) ? SumSat : s[55:0];
      end
    end
    if (lp || lb) begin
      div  = (points_per_path == 0) ? 11'd1 : points_per_path;
      mean = penalty_sum / div;
      if (mean > OutSat) mean = OutSat;
      r.penalty = mean[47:0];
      r.hits    = lb ? 5'($countones(hit_flags)) : 5'd0;
      r.done    = lb;
      if (lb) hit_flags = '0;
      penalty_sum = '0;
      penalty_q.insert(penalty_q.size(), r);
    end
  endtask

  task automatic absorb_word();
    int sl;
    sl = in_w.slot;
    case (in_w.op)
      OpLoadObs: begin
        if (sl < MaxObstacles) begin
          obs_kind[sl]   = in_w.kind;
          obs_cx[sl]     = in_w.coord_x;
          obs_cy[sl]     = in_w.coord_y;
          obs_radius[sl] = in_w.radius;
          obs_weight[sl] = in_w.weight;
          obs_vfirst[sl] = in_w.vertex_first;
          obs_vcount[sl] = in_w.vertex_count;
        end
      end
      OpLoadVtx: begin
        vtx_x[sl] = in_w.coord_x;
        vtx_y[sl] = in_w.coord_y;
      end
      OpPoint: accumulate_point(in_w.coord_x, in_w.coord_y,
                                in_w.last_in_path, in_w.last_in_batch);
      default: ;
    endcase
  endtask

  task automatic compare_result();
    penalty_res_t r;
    if (penalty_q.size() == 0) begin
      $error("result word with no expected result: penalty %0h", out_w.path_penalty_value);
      fail_o++;
    end else begin
      r = penalty_q.pop_front();
      if (out_w.path_penalty_value !== r.penalty) begin
        $error("path_penalty_value expected %0h actual %0h", r.penalty,
               out_w.path_penalty_value);
        fail_o++;
      end
      if (out_w.obstacles_hit !== r.hits) begin
        $error("obstacles_hit expected %0d actual %0d", r.hits, out_w.obstacles_hit);
        fail_o++;
      end
      if (out_w.batch_done !== r.done) begin
        $error("batch_done expected %0b actual %0b", r.done, out_w.batch_done);
        fail_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      penalty_sum     = '0;
      hit_flags       = '0;
      obstacle_count  = 5'd0;
      points_per_path = 11'd1;
      penalty_q.delete();
      pending_o       = 0;
      fail_o          = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgObstacleCount) obstacle_count = cfg_data_i[4:0];
        else points_per_path = cfg_data_i;
      end
      if (out_w.valid && out_w.ready) compare_result();
      if (in_w.valid && in_w.ready) absorb_word();
      pending_o = penalty_q.size();
    end
  end

endmodule

FILE: bench/testbench.sv
// Top of the obstacle accumulator bench: clock, reset, stimulus and verdict.
module testbench;
  import opa_pkg::*;

  localparam logic [1:0] OpNone      = 2'd3;
  localparam logic [1:0] KindEllipse = 2'd2;
  localparam logic [1:0] KindSpare   = 2'd3;
  localparam int         Unit        = 65536;
  localparam int         IdleLimit   = 50000;

  typedef struct {
    logic [1:0]  op;
    logic [5:0]  slot;
    logic [1:0]  kind;
    logic [31:0] x;
    logic [31:0] y;
    logic [30:0] radius;
    logic [30:0] weight;
    logic [5:0]  vfirst;
    logic [6:0]  vcount;
    logic        lp;
    logic        lb;
  } word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic        cfg_idx;
  logic [10:0] cfg_data;
  logic        quiet;
  int          fails;
  int          pending;
  int          idle_cycles = 0;

  opa_in_if  in_w();
  opa_out_if out_w();

  obstacle_penalty_accumulator_top u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_w),
    .out_o     (out_w)
  );

  opa_checker u_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_w      (in_w),
    .out_w     (out_w),
    .fail_o    (fails),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stall bursts, none once the run goes quiet.
  initial begin
    out_w.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_w.ready = 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk_i);
      end else begin
        out_w.ready = 1'b1;
      end
    end
  end

  function automatic word_t junk_word();
    word_t w;
    w.op     = 2'($urandom);
    w.slot   = 6'($urandom);
    w.kind   = 2'($urandom);
    w.x      = $urandom;
    w.y      = $urandom;
    w.radius = 31'($urandom);
    w.weight = 31'($urandom);
    w.vfirst = 6'($urandom);
    w.vcount = 7'($urandom);
    w.lp     = 1'($urandom);
    w.lb     = 1'($urandom);
    return w;
  endfunction

  function automatic word_t obs_word(int sl, logic [1:0] kind, int x, int y,
                                     int radius, int weight, int vf, int vc);
    word_t w;
    w        = junk_word();
    w.op     = OpLoadObs;
    w.slot   = 6'(sl);
    w.kind   = kind;
    w.x      = x;
    w.y      = y;
    w.radius = 31'(radius);
    w.weight = 31'(weight);
    w.vfirst = 6'(vf);
    w.vcount = 7'(vc);
    return w;
  endfunction

  function automatic word_t vtx_word(int sl, int x, int y);
    word_t w;
    w      = junk_word();
    w.op   = OpLoadVtx;
    w.slot = 6'(sl);
    w.x    = x;
    w.y    = y;
    return w;
  endfunction

  function automatic word_t pt_word(int x, int y, bit lp, bit lb);
    word_t w;
    w    = junk_word();
    w.op = OpPoint;
    w.x  = x;
    w.y  = y;
    w.lp = lp;
    w.lb = lb;
    return w;
  endfunction

  function automatic int arena(int half);
    return int'($urandom_range(0, 2 * half * Unit)) - half * Unit;
  endfunction

  task automatic send(input word_t w);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_w.valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_w.op            = w.op;
    in_w.slot          = w.slot;
    in_w.kind          = w.kind;
    in_w.coord_x       = w.x;
    in_w.coord_y       = w.y;
    in_w.radius        = w.radius;
    in_w.weight        = w.weight;
    in_w.vertex_first  = w.vfirst;
    in_w.vertex_count  = w.vcount;
    in_w.last_in_path  = w.lp;
    in_w.last_in_batch = w.lb;
    in_w.valid         = 1'b1;
    do @(posedge clk_i); while (!in_w.ready);
  endtask

  task automatic write_reg(input logic idx, input int val);
    @(negedge clk_i);
    in_w.valid = 1'b0;
    cfg_we     = 1'b1;
    cfg_idx    = idx;
    cfg_data   = 11'(val);
    @(negedge clk_i);
    cfg_we     = 1'b0;
  endtask

  // Waits for every result, then covers a point still being worked on.
  task automatic settle();
    @(negedge clk_i);
    in_w.valid = 1'b0;
    wait (pending == 0);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic square(int first, int cx, int cy, int h);
    send(vtx_word(first % MaxVertices, cx - h, cy - h));
    send(vtx_word((first + 1) % MaxVertices, cx + h, cy - h));
    send(vtx_word((first + 2) % MaxVertices, cx + h, cy + h));
    send(vtx_word((first + 3) % MaxVertices, cx - h, cy + h));
  endtask

  task automatic load_shape(int ob);
    int r;
    int cx;
    int cy;
    int wt;
    r  = $urandom_range(0, 9);
    cx = arena(20);
    cy = arena(20);
    wt = ($urandom_range(0, 7) == 0) ? int'($urandom & 32'h7fff_ffff)
                                      : int'($urandom_range(1, 8 * Unit));
    if (r < 5) begin
      send(obs_word(ob, KindCircle, cx, cy, $urandom_range(Unit, 10 * Unit), wt,
                    $urandom_range(0, 63), $urandom_range(0, 127)));
    end else if (r < 9) begin
      square(4 * ob, cx, cy, $urandom_range(2 * Unit, 8 * Unit));
      send(obs_word(ob, KindConvex, cx, cy, $urandom, wt, 4 * ob, $urandom_range(3, 4)));
    end else begin
      send(obs_word(ob, ($urandom_range(0, 1) != 0) ? KindEllipse : KindSpare, cx, cy,
                    $urandom, wt, $urandom_range(0, 63), $urandom_range(0, 127)));
    end
  endtask

  task automatic noise_word();
    word_t w;
    w = junk_word();
    case ($urandom_range(0, 2))
      0: w.op = OpNone;
      1: begin
        w.op   = OpLoadObs;
        w.slot = 6'($urandom_range(MaxObstacles, 63));
      end
      default: w.op = OpLoadVtx;
    endcase
    send(w);
  endtask

  function automatic int pick_coord();
    return ($urandom_range(0, 9) == 0) ? int'($urandom) : arena(25);
  endfunction

  task automatic run_phase(int words);
    int sent;
    int len;
    int r;
    bit lb;
    sent = 0;
    while (sent < words) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        load_shape($urandom_range(0, MaxObstacles - 1));
        sent++;
      end else if (r < 17) begin
        noise_word();
      end else begin
        len = $urandom_range(1, 5);
        lb  = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len - 1; i++) send(pt_word(pick_coord(), pick_coord(), 0, 0));
        // A batch mark alone also closes the path.
        if (lb && $urandom_range(0, 4) == 0) send(pt_word(pick_coord(), pick_coord(), 0, 1));
        else send(pt_word(pick_coord(), pick_coord(), 1, lb));
        sent += len;
      end
    end
    send(pt_word(pick_coord(), pick_coord(), 1, 1));
  endtask

  initial begin
    int counts[10];
    int divs[10];
    counts = '{16, 1, 0, 31, 4, 8, 2, 16, 6, 17};
    divs   = '{1, 1024, 0, 2047, 3, 1, 5, 2, 8, 1};
    quiet         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CfgObstacleCount;
    cfg_data      = '0;
    in_w.valid    = 1'b0;
    in_w.op       = OpNone;
    in_w.slot     = '0;
    in_w.kind     = KindCircle;
    in_w.coord_x  = '0;
    in_w.coord_y  = '0;
    in_w.radius   = '0;
    in_w.weight   = '0;
    in_w.vertex_first  = '0;
    in_w.vertex_count  = '0;
    in_w.last_in_path  = 1'b0;
    in_w.last_in_batch = 1'b0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Fill both tables so that no entry is read before it is written.
    for (int v = 0; v < MaxVertices; v++) send(vtx_word(v, $urandom, $urandom));
    for (int o = 0; o < MaxObstacles; o++) load_shape(o);

    write_reg(CfgObstacleCount, 3);
    write_reg(CfgPointsPerPath, 1);
    send(obs_word(0, KindCircle, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0));
    square(4, 0, 0, 2 * Unit);
    send(obs_word(1, KindConvex, Unit, Unit, 0, Unit, 4, 4));
    send(obs_word(2, KindEllipse, 0, 0, 32'h7fff_ffff, Unit, 0, 0));
    // Zero distance to a centre saturates the sum and the mean.
    send(pt_word(0, 0, 1, 0));
    send(pt_word(Unit, Unit / 2, 1, 1));
    send(pt_word(32'h8000_0000, 32'h8000_0000, 1, 0));
    send(pt_word(32'h7fff_ffff, 32'h7fff_ffff, 1, 0));
    send(pt_word(3 * Unit, 0, 0, 1));
    // Polygon whose vertex slots wrap past the end of the table.
    square(62, 10 * Unit, 10 * Unit, 3 * Unit);
    send(obs_word(2, KindConvex, 9 * Unit, 9 * Unit, 0, 2 * Unit, 62, 4));
    send(pt_word(10 * Unit, 10 * Unit, 1, 0));
    send(obs_word(1, KindConvex, Unit, Unit, 0, Unit, 0, 0));
    send(pt_word(Unit / 2, Unit / 2, 1, 0));
    send(obs_word(1, KindConvex, Unit, Unit, 0, Unit, 0, 127));
    send(obs_word(2, KindConvex, Unit, Unit, 0, Unit, 63, 64));
    send(pt_word(Unit / 2, Unit / 2, 1, 0));
    send(obs_word(2, KindSpare, 0, 0, 32'h7fff_ffff, Unit, 0, 0));
    send(pt_word(0, Unit, 1, 1));
    settle();
    write_reg(CfgPointsPerPath, 0);
    send(pt_word(0, 0, 1, 0));
    settle();
    write_reg(CfgPointsPerPath, 2047);
    write_reg(CfgObstacleCount, 31);
    send(pt_word(Unit, 0, 1, 1));
    for (int o = 0; o < MaxObstacles; o++) load_shape(o);
    send(pt_word(0, 0, 1, 1));

    for (int ph = 0; ph < 10; ph++) begin
      settle();
      write_reg(CfgObstacleCount, counts[ph]);
      write_reg(CfgPointsPerPath, divs[ph]);
      if (ph == 9) quiet = 1'b1;
      run_phase(72);
    end

    @(negedge clk_i);
    in_w.valid = 1'b0;
    wait (pending == 0);
    repeat (300) @(posedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
